/* design/tdlu_pkg.sv */
package tdlu_pkg;

  // tree size and lift depth
  localparam int unsigned NODES       = 1024;
  localparam int unsigned LIFT_LEVELS = 10;

  // field widths
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned LEN_W   = 11;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // ancestor table addressing: {level, node}
  localparam int unsigned LVL_W       = $clog2(LIFT_LEVELS + 1);
  localparam int unsigned ANC_AW      = LVL_W + NODE_W;
  localparam int unsigned ANC_ENTRIES = (LIFT_LEVELS + 1) * NODES;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_DEPTH,
    ST_LD_LIFT,
    ST_Q_DEPTH,
    ST_Q_DIFF,
    ST_Q_LIFT1,
    ST_Q_CHECK,
    ST_Q_LIFT2,
    ST_DONE
  } eng_state_e;

endpackage

/* design/tree_distance_binary_lifting_unit.sv */
// Tree distance unit using a binary-lifting ancestor table.
// Input stream (s_axis): tuser selects the operation, 0 loads a node with
// its parent (a root names itself), 1 asks for the edge distance of two
// nodes. Nodes must be loaded parent-first, and queried only once loaded.
// Output stream (m_axis): one transaction per query carrying the path length;
// loads produce nothing.
// Inputs enter a two-entry queue, so the source keeps going while the
// engine works and while a result waits for the sink.
// A load writes the level 0 entry, then one ancestor level per cycle from
// the dependent table reads. A query reads the depths, takes their gap,
// lifts the deeper node one level per cycle, checks whether they meet, lifts
// both nodes together and hands off the result; when one node is an ancestor
// of the other it skips the joint lift.
// Items are worked on one at a time; the table reads set the pace.
// Reset clears control state only; table and depth contents are undefined
// until loaded, and no clearing pass runs.
// A stalled sink holds the result register; the engine then waits at the
// end of its next query and the queue fills, dropping s_axis_tready_o.
module tree_distance_binary_lifting_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [tdlu_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,   // node_a, node_b, zero pad
  input  logic                                 s_axis_tuser_i,   // operation
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [tdlu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o    // path_length, zero pad
);

  tdlu_pkg::item_t                q_item;
  logic                           q_valid, q_ready;
  logic [tdlu_pkg::LEN_W-1:0]     res_len;

  // input queue and decode
  tdlu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_user_i  (s_axis_tuser_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  // table maintenance and distance walk
  tdlu_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_len_o    (res_len)
  );

  assign m_axis_tdata_o = {{(tdlu_pkg::OUT_TDATA_W - tdlu_pkg::LEN_W){1'b0}}, res_len};

endmodule

/* design/tdlu_front.sv */
module tdlu_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [tdlu_pkg::IN_TDATA_W-1:0]       s_data_i,
  input  logic                                  s_user_i,
  output logic                                  q_valid_o,
  input  logic                                  q_ready_i,
  output tdlu_pkg::item_t                       q_item_o
);

  localparam int unsigned PTR_W = $clog2(tdlu_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(tdlu_pkg::QUEUE_DEPTH + 1);

  tdlu_pkg::item_t  buf_q [tdlu_pkg::QUEUE_DEPTH];
  tdlu_pkg::item_t  item_in;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  // unpack and classify the incoming transaction
  always_comb begin
    item_in.kind   = tdlu_pkg::op_e'(s_user_i);
    item_in.node_a = s_data_i[tdlu_pkg::NODE_W-1:0];
    item_in.node_b = s_data_i[2*tdlu_pkg::NODE_W-1:tdlu_pkg::NODE_W];
  end

  assign s_ready_o = (count_q != CNT_W'(tdlu_pkg::QUEUE_DEPTH));
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = buf_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(tdlu_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");

endmodule

/* design/tdlu_engine.sv */
module tdlu_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  tdlu_pkg::item_t               item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [tdlu_pkg::LEN_W-1:0]    res_len_o
);

  localparam int unsigned NODE_W  = tdlu_pkg::NODE_W;
  localparam int unsigned DEPTH_W = tdlu_pkg::DEPTH_W;
  localparam int unsigned LEN_W   = tdlu_pkg::LEN_W;
  localparam int unsigned LVL_W   = tdlu_pkg::LVL_W;
  localparam int unsigned ANC_AW  = tdlu_pkg::ANC_AW;
  localparam int unsigned DIFF_W  = tdlu_pkg::LIFT_LEVELS + 1;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(tdlu_pkg::LIFT_LEVELS);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // saturating path length add
  function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] acc, logic [LEN_W:0] inc);
    logic [LEN_W+1:0] sum;
    sum = {2'b00, acc} + {1'b0, inc};
    if (sum > {2'b00, LEN_MAX}) begin
      sat_add = LEN_MAX;
    end else begin
      sat_add = sum[LEN_W-1:0];
    end
  endfunction

  // memories
  logic [NODE_W-1:0]  anc_mem [tdlu_pkg::ANC_ENTRIES];
  logic [DEPTH_W-1:0] dep_mem [tdlu_pkg::NODES];

  tdlu_pkg::eng_state_e state_q, state_d;
  logic [NODE_W-1:0]  u_q, u_d, v_q, v_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d, lvl_dn;
  logic [DIFF_W-1:0]  diff_q, diff_d;
  logic [LEN_W-1:0]   len_q, len_d, len_step, len_last;
  logic [LEN_W:0]     step_inc;
  logic               pend_q, pend_d;
  logic               res_valid_q, res_valid_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;

  logic               anc_we;
  logic [ANC_AW-1:0]  anc_waddr, anc_raddr_a, anc_raddr_b;
  logic [NODE_W-1:0]  anc_wdata, anc_rdata_a, anc_rdata_a_q, anc_rdata_b_q;
  logic               byp_q, byp_d;
  logic [NODE_W-1:0]  byp_data_q;
  logic               dep_we;
  logic [NODE_W-1:0]  dep_waddr, dep_raddr_a, dep_raddr_b;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata_a_q, dep_rdata_b_q, depth_gap;
  logic [NODE_W-1:0]  u_now, u_nx, v_nx;
  logic               pair_split, a_shallower;

  // read data with write-to-read forwarding on port a
  assign anc_rdata_a = byp_q ? byp_data_q : anc_rdata_a_q;

  // shared datapath terms
  assign u_now       = pend_q ? anc_rdata_a : u_q;
  assign pair_split  = (anc_rdata_a != anc_rdata_b_q);
  assign u_nx        = pair_split ? anc_rdata_a : u_q;
  assign v_nx        = pair_split ? anc_rdata_b_q : v_q;
  assign lvl_dn      = lvl_q - LVL_W'(1);
  assign step_inc    = (LEN_W + 1)'(2) << lvl_q;
  assign len_step    = pair_split ? sat_add(len_q, step_inc) : len_q;
  assign len_last    = sat_add(len_step, (LEN_W + 1)'(2));
  assign a_shallower = (dep_rdata_a_q < dep_rdata_b_q);
  assign depth_gap   = a_shallower ? dep_rdata_b_q - dep_rdata_a_q
                                   : dep_rdata_a_q - dep_rdata_b_q;

  // sequencer: next state, memory ports and datapath updates
  always_comb begin
    state_d      = state_q;
    u_d          = u_q;
    v_d          = v_q;
    lvl_d        = lvl_q;
    diff_d       = diff_q;
    len_d        = len_q;
    pend_d       = 1'b0;
    res_valid_d  = res_valid_q;
    res_len_d    = res_len_q;
    item_ready_o = 1'b0;
    anc_we       = 1'b0;
    anc_waddr    = {lvl_q, u_q};
    anc_wdata    = v_q;
    anc_raddr_a  = {lvl_q, u_q};
    anc_raddr_b  = {lvl_q, v_q};
    dep_we       = 1'b0;
    dep_waddr    = u_q;
    dep_wdata    = '0;
    dep_raddr_a  = u_q;
    dep_raddr_b  = v_q;

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      tdlu_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          u_d     = item_i.node_a;
          v_d     = item_i.node_b;
          state_d = (item_i.kind == tdlu_pkg::OP_LOAD) ? tdlu_pkg::ST_LD_DEPTH
                                                       : tdlu_pkg::ST_Q_DEPTH;
        end
      end
      // level 0 row entry, fetch parent depth and parent's level 0 ancestor
      tdlu_pkg::ST_LD_DEPTH: begin
        dep_raddr_a = v_q;
        anc_we      = 1'b1;
        anc_waddr   = {LVL_W'(0), u_q};
        anc_wdata   = v_q;
        anc_raddr_a = {LVL_W'(0), v_q};
        lvl_d       = LVL_W'(1);
        state_d     = tdlu_pkg::ST_LD_LIFT;
      end
      // one ancestor level per cycle, depth written on the first
      tdlu_pkg::ST_LD_LIFT: begin
        dep_raddr_a = v_q;
        anc_we      = 1'b1;
        anc_waddr   = {lvl_q, u_q};
        anc_wdata   = anc_rdata_a;
        anc_raddr_a = {lvl_q, anc_rdata_a};
        if (lvl_q == LVL_W'(1)) begin
          dep_we    = 1'b1;
          dep_wdata = (u_q == v_q) ? '0 : dep_rdata_a_q + DEPTH_W'(1);
        end
        if (lvl_q == LVL_TOP) begin
          state_d = tdlu_pkg::ST_IDLE;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      tdlu_pkg::ST_Q_DEPTH: begin
        dep_raddr_a = u_q;
        dep_raddr_b = v_q;
        state_d     = tdlu_pkg::ST_Q_DIFF;
      end
      // make u the deeper node
      tdlu_pkg::ST_Q_DIFF: begin
        if (a_shallower) begin
          u_d = v_q;
          v_d = u_q;
        end
        diff_d  = DIFF_W'(depth_gap);
        len_d   = LEN_W'(depth_gap);
        lvl_d   = LVL_TOP;
        state_d = tdlu_pkg::ST_Q_LIFT1;
      end
      // lift u by the set bits of the depth gap
      tdlu_pkg::ST_Q_LIFT1: begin
        u_d         = u_now;
        anc_raddr_a = {lvl_q, u_now};
        pend_d      = diff_q[lvl_q];
        if (lvl_q == '0) begin
          state_d = tdlu_pkg::ST_Q_CHECK;
        end else begin
          lvl_d = lvl_dn;
        end
      end
      tdlu_pkg::ST_Q_CHECK: begin
        u_d = u_now;
        if (u_now == v_q) begin
          state_d = tdlu_pkg::ST_DONE;
        end else begin
          lvl_d       = LVL_TOP;
          anc_raddr_a = {LVL_TOP, u_now};
          anc_raddr_b = {LVL_TOP, v_q};
          state_d     = tdlu_pkg::ST_Q_LIFT2;
        end
      end
      // lift both while their ancestors differ
      tdlu_pkg::ST_Q_LIFT2: begin
        u_d = u_nx;
        v_d = v_nx;
        if (lvl_q == '0) begin
          len_d   = len_last;
          state_d = tdlu_pkg::ST_DONE;
        end else begin
          len_d       = len_step;
          lvl_d       = lvl_dn;
          anc_raddr_a = {lvl_dn, u_nx};
          anc_raddr_b = {lvl_dn, v_nx};
        end
      end
      tdlu_pkg::ST_DONE: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          res_len_d   = len_q;
          state_d     = tdlu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdlu_pkg::ST_IDLE;
      end
    endcase
  end

  assign byp_d = anc_we && (anc_waddr == anc_raddr_a);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdlu_pkg::ST_IDLE;
      lvl_q       <= '0;
      pend_q      <= 1'b0;
      byp_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      pend_q      <= pend_d;
      byp_q       <= byp_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    diff_q     <= diff_d;
    len_q      <= len_d;
    res_len_q  <= res_len_d;
    byp_data_q <= anc_wdata;
  end

  // ancestor table, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    anc_rdata_a_q <= anc_mem[anc_raddr_a];
    anc_rdata_b_q <= anc_mem[anc_raddr_b];
  end

  // depth store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    dep_rdata_a_q <= dep_mem[dep_raddr_a];
    dep_rdata_b_q <= dep_mem[dep_raddr_b];
  end

  assign res_valid_o = res_valid_q;
  assign res_len_o   = res_len_q;

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_TOP)
    else $error("lift level out of range");

  a_write_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anc_we |-> (state_q == tdlu_pkg::ST_LD_DEPTH || state_q == tdlu_pkg::ST_LD_LIFT))
    else $error("ancestor table written outside a load");

  a_no_fwd_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdlu_pkg::ST_Q_LIFT2) |-> !byp_q)
    else $error("forwarding active during joint lift");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == tdlu_pkg::ST_DONE)
    else $error("result raised outside completion");

endmodule

/* verif/tb_tree_distance_binary_lifting_unit.sv */
module tb_tree_distance_binary_lifting_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES       = tdlu_pkg::NODES;
  localparam int unsigned LIFT_LEVELS = tdlu_pkg::LIFT_LEVELS;
  localparam int unsigned NODE_W      = tdlu_pkg::NODE_W;
  localparam int unsigned DEPTH_W     = tdlu_pkg::DEPTH_W;
  localparam int unsigned LEN_W       = tdlu_pkg::LEN_W;
  localparam int unsigned IN_TDATA_W  = tdlu_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = tdlu_pkg::OUT_TDATA_W;

  localparam int unsigned LEN_SAT  = (1 << LEN_W) - 1;
  localparam int unsigned IN_PAD_W = IN_TDATA_W - 2 * NODE_W;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - LEN_W;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned CHAIN_LEN = 256;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // gap control shared by both sides
  bit                     burst_mode = 1'b0;

  // items waiting for the driver, the one on the bus, path lengths still due
  tdlu_pkg::item_t        pend_q[$];
  tdlu_pkg::item_t        bus_item;
  logic [LEN_W-1:0]       path_len_q[$];
  int unsigned            src_gap = 0;
  int unsigned            sink_stall = 0;
  int unsigned            stall_pick = 0;
  int unsigned            bad_cnt = 0;
  logic [OUT_TDATA_W-1:0] want_word;

  // stimulus bookkeeping: nodes that hold a full ancestor row
  bit                     node_known [NODES];
  int                     known_q[$];
  int unsigned            item_cnt = 0;

  // tree state as the block should hold it
  logic [NODE_W-1:0]      anc_tbl [NODES][LIFT_LEVELS+1];
  logic [DEPTH_W-1:0]     depth_tbl [NODES];

  tree_distance_binary_lifting_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // node_a, node_b, zero pad
    .s_axis_tuser_i  (s_axis_tuser),   // operation
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)    // path_length, zero pad
  );

  // clock and reset
  always #6 clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // store depth and ancestor row of a loaded node
  function automatic void tree_load(logic [NODE_W-1:0] node, logic [NODE_W-1:0] parent);
    int i;
    depth_tbl[node] = (node == parent) ? '0 : depth_tbl[parent] + 1'b1;
    anc_tbl[node][0] = parent;
    for (i = 1; i <= LIFT_LEVELS; i++) begin
      anc_tbl[node][i] = anc_tbl[anc_tbl[node][i-1]][i-1];
    end
  endfunction

  function automatic int unsigned sat_add(int unsigned acc, int unsigned inc);
    return (acc + inc > LEN_SAT) ? LEN_SAT : acc + inc;
  endfunction

  // edge count between two nodes by lifting
  function automatic logic [LEN_W-1:0] tree_distance(logic [NODE_W-1:0] u,
                                                      logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] x, y, t, px, py;
    int unsigned       diff, len;
    int                i;
    x = u;
    y = v;
    if (depth_tbl[x] < depth_tbl[y]) begin
      t = x;
      x = y;
      y = t;
    end
    diff = int'(depth_tbl[x]) - int'(depth_tbl[y]);
    len = 0;
    // bring the deeper node up to the same depth
    for (i = LIFT_LEVELS; i >= 0; i--) begin
      if (diff >= (1 << i)) begin
        diff -= (1 << i);
        len = sat_add(len, 1 << i);
        x = anc_tbl[x][i];
      end
    end
    if (x == y) return len[LEN_W-1:0];
    // climb together while the ancestors still differ
    for (i = LIFT_LEVELS; i >= 0; i--) begin
      px = anc_tbl[x][i];
      py = anc_tbl[y][i];
      if (px != py) begin
        len = sat_add(len, 2 << i);
        x = px;
        y = py;
      end
    end
    len = sat_add(len, 2);
    return len[LEN_W-1:0];
  endfunction

  // source side: present queued items with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (bus_item.kind == tdlu_pkg::OP_LOAD) begin
          tree_load(bus_item.node_a, bus_item.node_b);
        end else begin
          path_len_q = {path_len_q, tree_distance(bus_item.node_a, bus_item.node_b)};
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current transaction
      end else if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        bus_item = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= bus_item.kind;
        s_axis_tdata <= {{IN_PAD_W{1'b0}}, bus_item.node_b, bus_item.node_a};
        src_gap <= burst_mode ? 0 : $urandom_range(0, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side: random stall after each result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_pick = burst_mode ? 0 : $urandom_range(0, 10);
      sink_stall <= stall_pick;
      m_axis_tready <= (stall_pick == 0);
    end else if (sink_stall > 1) begin
      sink_stall <= sink_stall - 1;
    end else begin
      sink_stall <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (path_len_q.size() == 0) begin
        if (bad_cnt < 10) $display("unexpected result: got %0d", m_axis_tdata);
        bad_cnt++;
      end else begin
        want_word = {{OUT_PAD_W{1'b0}}, path_len_q.pop_front()};
        if (m_axis_tdata !== want_word) begin
          if (bad_cnt < 10) begin
            $display("path_length mismatch: expected %0d, got %0d", want_word, m_axis_tdata);
          end
          bad_cnt++;
        end
      end
    end
  end

  function automatic int pick_known();
    return known_q[$urandom_range(0, known_q.size() - 1)];
  endfunction

  task automatic push_load(int node, int parent);
    tdlu_pkg::item_t it;
    it.kind = tdlu_pkg::OP_LOAD;
    it.node_a = node[NODE_W-1:0];
    it.node_b = parent[NODE_W-1:0];
    pend_q = {pend_q, it};
    if (!node_known[node]) begin
      node_known[node] = 1'b1;
      known_q = {known_q, node};
    end
    item_cnt++;
  endtask

  task automatic push_query(int a, int b);
    tdlu_pkg::item_t it;
    it.kind = tdlu_pkg::OP_QUERY;
    it.node_a = a[NODE_W-1:0];
    it.node_b = b[NODE_W-1:0];
    pend_q = {pend_q, it};
    item_cnt++;
  endtask

  // hold the source until every transaction is through and every result is back
  task automatic wait_idle();
    while (!(pend_q.size() == 0 && !s_axis_tvalid && path_len_q.size() == 0)) begin
      @(posedge clk_i);
    end
  endtask

  // one well-formed tree with random queries and a little noise
  task automatic tree_phase(int n_nodes, int n_queries);
    bit in_tree [NODES];
    int members[$];
    int loads_left, queries_left, node, par, a, b;
    loads_left = n_nodes - 1;
    queries_left = n_queries;
    node = $urandom_range(0, NODES - 1);
    push_load(node, node);
    in_tree[node] = 1'b1;
    members = {members, node};
    while (loads_left > 0 || queries_left > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        // reload a known node under any known parent, may break the tree
        a = pick_known();
        b = ($urandom_range(0, 3) == 0) ? a : pick_known();
        push_load(a, b);
      end else if (loads_left > 0 && (queries_left == 0 || $urandom_range(0, 1) == 0)) begin
        do node = $urandom_range(0, NODES - 1); while (in_tree[node]);
        if ($urandom_range(0, 1) == 0) par = members[members.size() - 1];
        else par = members[$urandom_range(0, members.size() - 1)];
        push_load(node, par);
        in_tree[node] = 1'b1;
        members = {members, node};
        loads_left--;
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          a = members[$urandom_range(0, members.size() - 1)];
          b = members[$urandom_range(0, members.size() - 1)];
        end else begin
          a = pick_known();
          b = pick_known();
        end
        push_query(a, b);
        queries_left--;
      end
    end
  endtask

  // long chain, then close it on itself into a cycle
  task automatic chain_phase();
    int perm [NODES];
    int i, j, t;
    for (i = 0; i < NODES; i++) perm[i] = i;
    for (i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    push_load(perm[0], perm[0]);
    for (i = 1; i < CHAIN_LEN; i++) push_load(perm[i], perm[i-1]);
    push_query(perm[CHAIN_LEN-1], perm[0]);
    push_query(perm[0], perm[CHAIN_LEN-1]);
    repeat (10) push_query(perm[$urandom_range(0, CHAIN_LEN-1)],
                           perm[$urandom_range(0, CHAIN_LEN-1)]);
    push_load(perm[0], perm[CHAIN_LEN-1]);
    push_query(perm[0], perm[CHAIN_LEN-1]);
    repeat (15) push_query(perm[$urandom_range(0, CHAIN_LEN-1)],
                           perm[$urandom_range(0, CHAIN_LEN-1)]);
  endtask

  // stimulus
  initial begin
    int unsigned rand_end, n;
    @(posedge rst_ni);

    // directed: extreme indices, ancestor pairs, second root, cycle
    push_load(0, 0);
    push_query(0, 0);
    push_load(1023, 0);
    push_load(512, 1023);
    push_load(341, 512);
    push_load(682, 512);
    push_query(341, 682);
    push_query(0, 341);
    push_query(341, 0);
    push_query(1023, 1023);
    push_load(777, 777);
    push_query(777, 0);
    push_query(682, 777);
    push_load(0, 682);
    push_query(0, 341);
    push_query(1023, 682);
    push_load(0, 0);
    push_query(682, 1023);
    wait_idle();

    // random trees, mostly small, a few larger
    rand_end = item_cnt + RANDOM_ITEMS;
    while (item_cnt < rand_end) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(2, 25);
      tree_phase(n, $urandom_range(n / 2, n + 4));
      wait_idle();
    end

    burst_mode = 1'b0;
    chain_phase();
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
